/* rtl/heartbeat_timeout_monitor_macros.svh */
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor assertion macros
// Shared assertion forms for the heartbeat timeout monitor, clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_TIMEOUT_MONITOR_MACROS_SVH
`define HEARTBEAT_TIMEOUT_MONITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/htm_pkg.sv */
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor package
// Widths, register indexes, parameter defaults and the operation type.
// ----------------------------------------------------------------------------
package htm_pkg;

    localparam int BITS_W       = 7;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int TIMEOUT_W    = 16;
    localparam int CHAN_W       = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_CHANNELS = 7;

    localparam logic [CFG_IDX_W-1:0] REG_GRACE = 3'd7;

    localparam int                DEF_CHANNELS    = 7;
    localparam logic [BITS_W-1:0] DEF_SAFETY_MASK = 7'd111;
    localparam logic [BITS_W-1:0] DEF_LOGGER_MASK = 7'd16;

    typedef enum logic [1:0] {
        KIND_RESTART = 2'd0,
        KIND_KICK    = 2'd1,
        KIND_CHECK   = 2'd2
    } kind_t;

endpackage

/* rtl/heartbeat_timeout_monitor.sv */
// A result is registered as its item leaves the input register.
// Throughput: one item per cycle unless the output stalls; the input register
// and the result register form a two-stage pipeline, and the channel state is
// updated as an item leaves the input register, so consecutive items see each
// other's effects.
// Reset clears the pipeline, all channel state and the configuration registers.
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor
// Multi-channel heartbeat watchdog with restart, kick and check operations,
// per-channel timeouts, a startup grace period and safety and logger masks.
// ----------------------------------------------------------------------------
`include "heartbeat_timeout_monitor_macros.svh"

module heartbeat_timeout_monitor
    import htm_pkg::*;
#(
    parameter int                CHANNELS    = DEF_CHANNELS,
    parameter logic [BITS_W-1:0] SAFETY_MASK = DEF_SAFETY_MASK,
    parameter logic [BITS_W-1:0] LOGGER_MASK = DEF_LOGGER_MASK
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMEOUT_W-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [TIME_W-1:0]    now_ms,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BITS_W-1:0]    stale_bits,
    output logic [BITS_W-1:0]    seen_bits,
    output logic [BITS_W-1:0]    safety_stale_bits,
    output logic [BITS_W-1:0]    logger_stale_bits,
    output logic                 safety_fault,
    output logic                 logger_fault,
    output logic [COUNT_W-1:0]   kick_total
);

    logic [TIMEOUT_W-1:0] timeout_reg [CHANNELS];
    logic [TIMEOUT_W-1:0] grace_reg;

    logic                 s1_valid_reg;
    kind_t                s1_kind_reg;
    logic [CHAN_W-1:0]    s1_channel_reg;
    logic [TIME_W-1:0]    s1_now_reg;
    logic                 s1_advance;

    logic [TIME_W-1:0]    boot_time_reg;
    logic [TIME_W-1:0]    boot_time_next;
    logic [TIME_W-1:0]    last_kick_reg  [CHANNELS];
    logic [TIME_W-1:0]    last_kick_next [CHANNELS];
    logic [COUNT_W-1:0]   kick_count_reg  [CHANNELS];
    logic [COUNT_W-1:0]   kick_count_next [CHANNELS];
    logic [CHANNELS-1:0]  seen_reg;
    logic [CHANNELS-1:0]  seen_next;
    logic [CHANNELS-1:0]  stale_reg;
    logic [CHANNELS-1:0]  stale_next;

    logic [TIME_W-1:0]    since_boot;
    logic                 in_grace;
    logic [TIME_W-1:0]    since_kick [CHANNELS];
    logic [CHANNELS-1:0]  stale_calc;
    logic [CHANNELS-1:0]  hit;
    logic [COUNT_W-1:0]   kick_total_next;
    logic [BITS_W-1:0]    stale_wide;

    logic                 out_valid_reg;
    logic [BITS_W-1:0]    stale_bits_reg;
    logic [BITS_W-1:0]    seen_bits_reg;
    logic [BITS_W-1:0]    safety_stale_reg;
    logic [BITS_W-1:0]    logger_stale_reg;
    logic                 safety_fault_reg;
    logic                 logger_fault_reg;
    logic [COUNT_W-1:0]   kick_total_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                timeout_reg[i] <= '0;
            end
            grace_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    timeout_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == REG_GRACE)
            begin
                grace_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg    <= kind_t'(kind);
            s1_channel_reg <= channel;
            s1_now_reg     <= now_ms;
        end
    end

    always_comb
    begin
        since_boot      = s1_now_reg - boot_time_reg;
        in_grace        = since_boot < {{(TIME_W-TIMEOUT_W){1'b0}}, grace_reg};
        boot_time_next  = boot_time_reg;
        seen_next       = seen_reg;
        stale_next      = stale_reg;
        kick_total_next = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            hit[i]             = (s1_channel_reg == CHAN_W'(i));
            since_kick[i]      = s1_now_reg - last_kick_reg[i];
            last_kick_next[i]  = last_kick_reg[i];
            kick_count_next[i] = kick_count_reg[i];
            if (timeout_reg[i] == '0)
            begin
                stale_calc[i] = 1'b0;
            end
            else if (seen_reg[i])
            begin
                stale_calc[i] =
                    since_kick[i] > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_reg[i]};
            end
            else
            begin
                stale_calc[i] = !in_grace;
            end
        end

        unique case (s1_kind_reg)
            KIND_RESTART:
            begin
                boot_time_next = s1_now_reg;
                seen_next      = '0;
                stale_next     = '0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    last_kick_next[i]  = s1_now_reg;
                    kick_count_next[i] = '0;
                end
            end
            KIND_KICK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (hit[i])
                    begin
                        last_kick_next[i] = s1_now_reg;
                        seen_next[i]      = 1'b1;
                        if (kick_count_reg[i] != '1)
                        begin
                            kick_count_next[i] = kick_count_reg[i] + COUNT_W'(1);
                        end
                    end
                end
            end
            KIND_CHECK:
            begin
                stale_next = stale_calc;
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < CHANNELS; i++)
        begin
            if (hit[i])
            begin
                kick_total_next = kick_count_next[i];
            end
        end
        stale_wide = BITS_W'(stale_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_time_reg <= '0;
            seen_reg      <= '0;
            stale_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_kick_reg[i]  <= '0;
                kick_count_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            boot_time_reg <= boot_time_next;
            seen_reg      <= seen_next;
            stale_reg     <= stale_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_kick_reg[i]  <= last_kick_next[i];
                kick_count_reg[i] <= kick_count_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            stale_bits_reg   <= stale_wide;
            seen_bits_reg    <= BITS_W'(seen_next);
            safety_stale_reg <= stale_wide & SAFETY_MASK;
            logger_stale_reg <= stale_wide & LOGGER_MASK;
            safety_fault_reg <= |(stale_wide & SAFETY_MASK);
            logger_fault_reg <= |(stale_wide & LOGGER_MASK);
            kick_total_reg   <= kick_total_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign stale_bits        = stale_bits_reg;
    assign seen_bits         = seen_bits_reg;
    assign safety_stale_bits = safety_stale_reg;
    assign logger_stale_bits = logger_stale_reg;
    assign safety_fault      = safety_fault_reg;
    assign logger_fault      = logger_fault_reg;
    assign kick_total        = kick_total_reg;

    `HTM_ASSERT_SAME(a_no_overwrite, out_valid_reg && !out_ready, !s1_advance, "result overwritten while stalled")
    `HTM_ASSERT_NEXT(a_restart_clears, s1_advance && s1_kind_reg == KIND_RESTART, seen_reg == '0 && stale_reg == '0, "restart did not clear masks")
    `HTM_ASSERT_NEXT(a_seen_grows, s1_advance && s1_kind_reg == KIND_KICK, (seen_reg & $past(seen_reg)) == $past(seen_reg) && stale_reg == $past(stale_reg), "kick lost seen bits or changed stale mask")

endmodule

/* verif/heartbeat_timeout_monitor_checker.sv */
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor checker
// Watches the register port and both channels of the heartbeat monitor. It
// keeps its own copy of the channel state and the timeouts, works out the
// status for every input transfer and compares each result transfer with
// the oldest status still waiting.
// ----------------------------------------------------------------------------
module heartbeat_timeout_monitor_checker
    import htm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMEOUT_W-1:0] cfg_data,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [TIME_W-1:0]    now_ms,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [BITS_W-1:0]    stale_bits,
    input  logic [BITS_W-1:0]    seen_bits,
    input  logic [BITS_W-1:0]    safety_stale_bits,
    input  logic [BITS_W-1:0]    logger_stale_bits,
    input  logic                 safety_fault,
    input  logic                 logger_fault,
    input  logic [COUNT_W-1:0]   kick_total,

    output int                   mismatches,
    output int                   results_seen,
    output int                   fault_results,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BITS_W-1:0]  stale;
        logic [BITS_W-1:0]  seen;
        logic [BITS_W-1:0]  safety;
        logic [BITS_W-1:0]  logger;
        logic               safety_flag;
        logic               logger_flag;
        logic [COUNT_W-1:0] kicks;
    } heartbeat_status_t;

    logic [TIMEOUT_W-1:0] limit_ms [MAX_CHANNELS];
    logic [TIMEOUT_W-1:0] grace_ms;

    logic [TIME_W-1:0]    boot_ms;
    logic [TIME_W-1:0]    last_kick_ms [MAX_CHANNELS];
    logic [COUNT_W-1:0]   kick_counts [MAX_CHANNELS];
    logic [BITS_W-1:0]    kicked_flags;
    logic [BITS_W-1:0]    expired_flags;

    heartbeat_status_t    status_expected_q [$];
    int                   mismatch_count;
    int                   result_count;
    int                   fault_count;

    function automatic heartbeat_status_t apply_heartbeat(logic [1:0] k,
                                                          logic [CHAN_W-1:0] ch,
                                                          logic [TIME_W-1:0] t);
        heartbeat_status_t s;
        logic [TIME_W-1:0] since_boot;
        logic              ch_ok;
        logic [2:0]        slot;
        ch_ok = ch < DEF_CHANNELS;
        slot  = ch[2:0];
        case (k)
            KIND_RESTART:
            begin
                boot_ms       = t;
                kicked_flags  = '0;
                expired_flags = '0;
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    last_kick_ms[i] = t;
                    kick_counts[i]  = '0;
                end
            end
            KIND_KICK:
            begin
                if (ch_ok)
                begin
                    last_kick_ms[slot] = t;
                    if (kick_counts[slot] != '1)
                        kick_counts[slot] = kick_counts[slot] + COUNT_W'(1);
                    kicked_flags[slot] = 1'b1;
                end
            end
            KIND_CHECK:
            begin
                since_boot    = t - boot_ms;
                expired_flags = '0;
                for (int i = 0; i < DEF_CHANNELS; i++)
                begin
                    if (limit_ms[i] != '0)
                    begin
                        if (!kicked_flags[i])
                            expired_flags[i] = since_boot >= TIME_W'(grace_ms);
                        else
                            expired_flags[i] = TIME_W'(t - last_kick_ms[i])
                                               > TIME_W'(limit_ms[i]);
                    end
                end
            end
            default:
            begin
            end
        endcase
        s.stale       = expired_flags;
        s.seen        = kicked_flags;
        s.safety      = expired_flags & DEF_SAFETY_MASK;
        s.logger      = expired_flags & DEF_LOGGER_MASK;
        s.safety_flag = |s.safety;
        s.logger_flag = |s.logger;
        s.kicks       = ch_ok ? kick_counts[slot] : '0;
        return s;
    endfunction

    task automatic compare_field(string field, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s wrong on result %0d: expected 0x%0h, got 0x%0h",
                         $time, field, result_count, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        heartbeat_status_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                limit_ms[i]     = '0;
                last_kick_ms[i] = '0;
                kick_counts[i]  = '0;
            end
            grace_ms       = '0;
            boot_ms        = '0;
            kicked_flags   = '0;
            expired_flags  = '0;
            status_expected_q.delete();
            mismatch_count = 0;
            result_count   = 0;
            fault_count    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRACE)
                    grace_ms = cfg_data;
                else
                    limit_ms[cfg_index] = cfg_data;
            end
            // The result side is handled first so that an input taken on the
            // same edge can never be matched against its own result.
            if (out_valid && out_ready)
            begin
                result_count++;
                if (safety_fault || logger_fault)
                    fault_count++;
                if (status_expected_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with nothing expected", $time);
                end
                else
                begin
                    want = status_expected_q.pop_front();
                    compare_field("stale_bits", COUNT_W'(stale_bits),
                                  COUNT_W'(want.stale));
                    compare_field("seen_bits", COUNT_W'(seen_bits),
                                  COUNT_W'(want.seen));
                    compare_field("safety_stale_bits", COUNT_W'(safety_stale_bits),
                                  COUNT_W'(want.safety));
                    compare_field("logger_stale_bits", COUNT_W'(logger_stale_bits),
                                  COUNT_W'(want.logger));
                    compare_field("safety_fault", COUNT_W'(safety_fault),
                                  COUNT_W'(want.safety_flag));
                    compare_field("logger_fault", COUNT_W'(logger_fault),
                                  COUNT_W'(want.logger_flag));
                    compare_field("kick_total", kick_total, want.kicks);
                end
            end
            if (in_valid && in_ready)
                status_expected_q.push_back(apply_heartbeat(kind, channel, now_ms));
        end
        mismatches    <= mismatch_count;
        results_seen  <= result_count;
        fault_results <= fault_count;
        pending       <= status_expected_q.size();
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor testbench
// Drives restarts, kicks and checks into the heartbeat monitor under several
// timeout and grace settings, with random gaps and output stalls. A checker
// beside the block predicts every result; this module makes the stimulus,
// watches for a hang and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import htm_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         QUIET_LIMIT = 400;
    localparam int         PHASE_ITEMS = 125;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [1:0]           kind      = '0;
    logic [CHAN_W-1:0]    channel   = '0;
    logic [TIME_W-1:0]    now_ms    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BITS_W-1:0]    stale_bits;
    logic [BITS_W-1:0]    seen_bits;
    logic [BITS_W-1:0]    safety_stale_bits;
    logic [BITS_W-1:0]    logger_stale_bits;
    logic                 safety_fault;
    logic                 logger_fault;
    logic [COUNT_W-1:0]   kick_total;

    int                   mismatches;
    int                   results_seen;
    int                   fault_results;
    int                   pending;

    bit                   steady_flow;
    logic [TIME_W-1:0]    wall_ms;
    int                   items_sent;
    int                   restarts_sent;
    int                   kicks_sent;
    int                   checks_sent;
    int                   unused_sent;
    int                   settings_applied;
    int                   quiet_cycles;

    heartbeat_timeout_monitor uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .channel           (channel),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .stale_bits        (stale_bits),
        .seen_bits         (seen_bits),
        .safety_stale_bits (safety_stale_bits),
        .logger_stale_bits (logger_stale_bits),
        .safety_fault      (safety_fault),
        .logger_fault      (logger_fault),
        .kick_total        (kick_total)
    );

    heartbeat_timeout_monitor_checker status_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .channel           (channel),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .stale_bits        (stale_bits),
        .seen_bits         (seen_bits),
        .safety_stale_bits (safety_stale_bits),
        .logger_stale_bits (logger_stale_bits),
        .safety_fault      (safety_fault),
        .logger_fault      (logger_fault),
        .kick_total        (kick_total),
        .mismatches        (mismatches),
        .results_seen      (results_seen),
        .fault_results     (fault_results),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("testbench: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int stall;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_item(logic [1:0] k, logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] t);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        channel  <= ch;
        now_ms   <= t;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        case (k)
            KIND_RESTART: restarts_sent++;
            KIND_KICK:    kicks_sent++;
            KIND_CHECK:   checks_sent++;
            default:      unused_sent++;
        endcase
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(logic [TIMEOUT_W-1:0] limits [MAX_CHANNELS],
                                  logic [TIMEOUT_W-1:0] grace);
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= limits[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRACE;
        cfg_data  <= grace;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_random_phase(int count, int span);
        int                roll;
        logic [1:0]        k;
        logic [CHAN_W-1:0] ch;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                steady_flow = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2: ;
                3:       wall_ms = wall_ms + $urandom;
                default: wall_ms = wall_ms + $urandom_range(0, span);
            endcase
            roll = $urandom_range(0, 99);
            ch   = CHAN_W'($urandom_range(0, 15));
            if (roll < 4)
            begin
                k = KIND_RESTART;
                if ($urandom_range(0, 1) == 1)
                    wall_ms = $urandom;
            end
            else if (roll < 54)
            begin
                k = KIND_KICK;
                ch = ($urandom_range(0, 19) == 0) ? CHAN_W'($urandom_range(7, 15))
                                                  : CHAN_W'($urandom_range(0, 6));
            end
            else if (roll < 92)
                k = KIND_CHECK;
            else if (roll < 96)
                k = KIND_UNUSED;
            else
            begin
                k  = KIND_KICK;
                ch = CHAN_W'($urandom_range(7, 15));
            end
            t = ($urandom_range(0, 29) == 0) ? $urandom : wall_ms;
            send_item(k, ch, t);
        end
    endtask

    initial
    begin
        logic [TIMEOUT_W-1:0] limits [MAX_CHANNELS];
        logic [TIMEOUT_W-1:0] grace;
        int                   span;

        steady_flow = 1'b0;
        wall_ms     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(KIND_CHECK, 4'd2, 32'h1234_5678);
        send_item(KIND_KICK, 4'd3, 32'h1234_5680);
        send_item(KIND_UNUSED, 4'd3, 32'h1234_5690);
        drain_results();

        limits = '{16'd100, 16'd1, 16'hFFFF, 16'd0, 16'd250, 16'd50, 16'd1000};
        program_limits(limits, 16'd20);
        send_item(KIND_RESTART, 4'd0, 32'hFFFF_FFF0);
        send_item(KIND_CHECK, 4'd1, 32'hFFFF_FFF5);
        send_item(KIND_KICK, 4'd0, 32'hFFFF_FFF8);
        send_item(KIND_KICK, 4'd1, 32'h0000_0002);
        send_item(KIND_CHECK, 4'd0, 32'h0000_0003);
        send_item(KIND_CHECK, 4'd1, 32'h0000_0004);
        send_item(KIND_KICK, 4'd7, 32'h0000_0005);
        send_item(KIND_KICK, 4'd15, 32'h0000_0006);
        send_item(KIND_UNUSED, 4'd0, 32'h0000_0007);
        for (int c = 2; c < MAX_CHANNELS; c++)
            send_item(KIND_KICK, CHAN_W'(c), 32'h0000_0010 + TIME_W'(c));
        send_item(KIND_KICK, 4'd0, 32'h0000_0020);
        send_item(KIND_CHECK, 4'd0, 32'h0000_0084);
        send_item(KIND_CHECK, 4'd0, 32'h0000_0085);
        send_item(KIND_CHECK, 4'd4, 32'h8000_0000);
        send_item(KIND_KICK, 4'd0, 32'h8000_0001);
        send_item(KIND_RESTART, 4'd3, 32'h0000_0000);
        send_item(KIND_CHECK, 4'd3, 32'hFFFF_FFFF);
        send_item(KIND_KICK, 4'd6, 32'hFFFF_FFFF);
        send_item(KIND_CHECK, 4'd6, 32'hFFFF_FFFF);
        drain_results();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        limits[i] = TIMEOUT_W'($urandom_range(1, 300));
                    grace = TIMEOUT_W'($urandom_range(0, 100));
                    span  = 300;
                end
                1:
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        limits[i] = 16'hFFFF;
                    grace = 16'hFFFF;
                    span  = 131070;
                end
                2:
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        limits[i] = 16'd1;
                    grace = 16'd0;
                    span  = 3;
                end
                3:
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        limits[i] = ($urandom_range(0, 2) == 0)
                                    ? 16'd0
                                    : TIMEOUT_W'($urandom_range(1, 1000));
                    grace = TIMEOUT_W'($urandom_range(0, 500));
                    span  = 1000;
                end
                4:
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        limits[i] = 16'd0;
                    grace = 16'd0;
                    span  = 1000;
                end
                default:
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        limits[i] = TIMEOUT_W'($urandom_range(0, 65535));
                    grace = TIMEOUT_W'($urandom_range(0, 65535));
                    span  = 65535;
                end
            endcase
            program_limits(limits, grace);
            run_random_phase(PHASE_ITEMS, span);
            drain_results();
        end

        steady_flow = 1'b0;
        repeat (6) @(posedge clk);

        $display("Sent %0d transfers: %0d restarts, %0d kicks, %0d checks, %0d unused kind.",
                 items_sent, restarts_sent, kicks_sent, checks_sent, unused_sent);
        $display("Checked %0d results under %0d timeout settings; %0d carried a fault flag.",
                 results_seen, settings_applied, fault_results);
        if (mismatches == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/htm_pkg.sv
rtl/heartbeat_timeout_monitor.sv
verif/heartbeat_timeout_monitor_checker.sv
verif/testbench.sv
